### rtl/vcfc_pkg.sv
// vcfc_pkg: shared constants, types and helpers of the voxel chunk face culler
// no dependencies; the interfaces, lane, face array and top refer to it by scoped names
`timescale 1ns / 1ps

package vcfc_pkg;

  // chunk edge in rows along i and j; a row always holds 32 voxels along k
  localparam int EDGE      = 32;
  localparam int ROW_W     = 32;
  localparam int COORD_W   = 10;
  localparam int WORLD_W   = 15;
  localparam int ROW_SHIFT = 5;   // world position scale of 32 per chunk
  localparam int IDX_W     = (EDGE > 1) ? $clog2(EDGE) : 1;
  localparam int DEPTH     = 2 * EDGE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Z = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_EMIT
  } state_t;

  // rows around the voxel row being reported
  typedef struct packed {
    logic [ROW_W-1:0] self;
    logic [ROW_W-1:0] prv;
    logic [ROW_W-1:0] nxt;
    logic [ROW_W-1:0] dn;
    logic [ROW_W-1:0] up;
  } nbr_t;

  // one voxel and its six neighbours, border already folded in as air
  typedef struct packed {
    logic self;
    logic prv;
    logic nxt;
    logic dn;
    logic up;
    logic lower;
    logic upper;
  } lane_in_t;

  typedef struct packed {
    logic left;
    logic right;
    logic bottom;
    logic top;
    logic front;
    logic back;
  } lane_faces_t;

  typedef struct packed {
    logic [ROW_W-1:0] left;
    logic [ROW_W-1:0] right;
    logic [ROW_W-1:0] bottom;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] front;
    logic [ROW_W-1:0] back;
  } faces_t;

  // plane store address of row idx in the plane slot given
  function automatic logic [ADDR_W-1:0] slot_addr(input logic slot,
                                                 input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(idx);
    if (slot) begin
      a = a + ADDR_W'(EDGE);
    end
    return a;
  endfunction

endpackage

### rtl/vcfc_if.sv
// vcfc_if: valid/ready channel interfaces for occupancy rows and face results
// depends on vcfc_pkg for field widths
`timescale 1ns / 1ps

interface vcfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [vcfc_pkg::ROW_W-1:0]  row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

interface vcfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [vcfc_pkg::WORLD_W-1:0]  world_x;
  logic [vcfc_pkg::WORLD_W-1:0]  world_y;
  logic [vcfc_pkg::WORLD_W-1:0]  world_z_base;
  logic [vcfc_pkg::ROW_W-1:0]    left_faces;
  logic [vcfc_pkg::ROW_W-1:0]    right_faces;
  logic [vcfc_pkg::ROW_W-1:0]    bottom_faces;
  logic [vcfc_pkg::ROW_W-1:0]    top_faces;
  logic [vcfc_pkg::ROW_W-1:0]    front_faces;
  logic [vcfc_pkg::ROW_W-1:0]    back_faces;
  logic                          chunk_done;

  modport source (output valid, output world_x, output world_y, output world_z_base,
                  output left_faces, output right_faces, output bottom_faces,
                  output top_faces, output front_faces, output back_faces,
                  output chunk_done, input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z_base,
                  input left_faces, input right_faces, input bottom_faces,
                  input top_faces, input front_faces, input back_faces,
                  input chunk_done, output ready);
endinterface

### rtl/vcfc_ram.sv
// vcfc_ram: generic RAM, one write port and two read ports with registered data
// no dependencies
`timescale 1ns / 1ps

module vcfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/vcfc_lane.sv
// vcfc_lane: face test of one voxel against its six neighbours
// depends on vcfc_pkg for the lane types
`timescale 1ns / 1ps

module vcfc_lane (
  input  vcfc_pkg::lane_in_t    nb,
  output vcfc_pkg::lane_faces_t faces
);

  // a face shows when the voxel is solid and the neighbour is air or border
  always_comb begin
    faces.left   = nb.self & ~nb.prv;
    faces.right  = nb.self & ~nb.nxt;
    faces.bottom = nb.self & ~nb.dn;
    faces.top    = nb.self & ~nb.up;
    faces.front  = nb.self & ~nb.lower;
    faces.back   = nb.self & ~nb.upper;
  end

endmodule

### rtl/vcfc_face_array.sv
// vcfc_face_array: one lane per voxel of a row, merged back into six face masks
// depends on vcfc_pkg and vcfc_lane
`timescale 1ns / 1ps

module vcfc_face_array (
  input  vcfc_pkg::nbr_t   rows,
  output vcfc_pkg::faces_t faces
);

  vcfc_pkg::lane_faces_t lane_out [vcfc_pkg::ROW_W];

  for (genvar k = 0; k < vcfc_pkg::ROW_W; k++) begin : g_lane
    vcfc_pkg::lane_in_t lane_nb;

    always_comb begin
      lane_nb.self = rows.self[k];
      lane_nb.prv  = rows.prv[k];
      lane_nb.nxt  = rows.nxt[k];
      lane_nb.dn   = rows.dn[k];
      lane_nb.up   = rows.up[k];
      // row ends along k count as air
      lane_nb.lower = (k == 0) ? 1'b0 : rows.self[(k == 0) ? 0 : k - 1];
      lane_nb.upper = (k == vcfc_pkg::ROW_W - 1) ? 1'b0 :
                      rows.self[(k == vcfc_pkg::ROW_W - 1) ? k : k + 1];
    end

    vcfc_lane u_lane (
      .nb    (lane_nb),
      .faces (lane_out[k])
    );
  end

  // merge: gather each lane's bits back into whole-row masks
  always_comb begin
    for (int k = 0; k < vcfc_pkg::ROW_W; k++) begin
      faces.left[k]   = lane_out[k].left;
      faces.right[k]  = lane_out[k].right;
      faces.bottom[k] = lane_out[k].bottom;
      faces.top[k]    = lane_out[k].top;
      faces.front[k]  = lane_out[k].front;
      faces.back[k]   = lane_out[k].back;
    end
  end

endmodule

### rtl/voxel_chunk_face_culler_top.sv
// voxel_chunk_face_culler_top: row sequencer, plane store and output register
// depends on vcfc_pkg, vcfc_if, vcfc_ram and vcfc_face_array
//
// Usage: a chunk streams in as EDGE*EDGE occupancy rows of 32 bits on in_chan, row
// index i slowest, then j. Each row (i, j) is reported on out_chan once row (i+1, j)
// arrives, with six face masks and its world coordinates; the last row of the chunk
// also flushes the whole final plane, and chunk_done marks its last result.
// Rows of the first plane go straight into the plane store and give no result. Every
// later row passes acceptance, three read states on the two-port plane store
// (own row and the row above, then the row below and the previous plane) and an
// emit step that loads the output register; its result is valid right after that.
// The last row of a chunk adds EDGE flush results, each through the read states and emit.
// The output register decouples the sides: a new row is accepted while a result
// still waits; a stalled receiver holds the result and the sequencer waits in its
// emit step until the register is free.
// cfg_we writes chunk_x, chunk_y or chunk_z (cfg_index 0..2) at any edge; results
// use the values current when they are loaded, so write them while idle.
// Reset (rst_n low, synchronous) returns to the start of a chunk, clears the
// coordinates and drops any pending result; the plane store needs no clearing.
`timescale 1ns / 1ps

module voxel_chunk_face_culler_top (
  input  logic                             clk,
  input  logic                             rst_n,
  vcfc_in_if.sink                          in_chan,
  vcfc_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [vcfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vcfc_pkg::COORD_W-1:0]     cfg_wdata
);

  localparam logic [vcfc_pkg::IDX_W-1:0] IDX_LAST = vcfc_pkg::IDX_W'(vcfc_pkg::EDGE - 1);
  localparam logic [vcfc_pkg::IDX_W-1:0] IDX_ZERO = '0;

  vcfc_pkg::state_t state_r, state_nxt;

  logic [vcfc_pkg::COORD_W-1:0] chunk_x_r, chunk_y_r, chunk_z_r;
  logic [vcfc_pkg::IDX_W-1:0]   i_r, j_r;       // next input row position
  logic [vcfc_pkg::IDX_W-1:0]   p_r, r_r;       // row being reported
  logic                         flush_r;
  logic                         last_r;
  logic [vcfc_pkg::ROW_W-1:0]   row_r;
  logic [vcfc_pkg::ROW_W-1:0]   nxt_r, self_r, up_r, dn_r, prv_r;

  logic                         out_valid_r;
  logic [vcfc_pkg::WORLD_W-1:0] world_x_r, world_y_r, world_z_r;
  vcfc_pkg::faces_t             faces_r;
  logic                         done_r;

  logic                         in_fire;
  logic                         out_free;
  logic                         emit_load;
  logic                         ram_we;
  logic [vcfc_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [vcfc_pkg::ROW_W-1:0]   ram_wdata, ram_rdata_a, ram_rdata_b;
  logic [vcfc_pkg::IDX_W-1:0]   r_up, r_dn;

  vcfc_pkg::nbr_t               nbr;
  vcfc_pkg::faces_t             faces;

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_fire  = in_chan.valid && in_chan.ready;

  // clamp neighbour addresses at the plane edges; the data is masked anyway
  assign r_up = (r_r == IDX_LAST) ? r_r : r_r + 1'b1;
  assign r_dn = (r_r == IDX_ZERO) ? r_r : r_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vcfc_pkg::ST_IDLE: begin
        if (in_chan.valid && i_r != IDX_ZERO) begin
          state_nxt = vcfc_pkg::ST_RD0;
        end
      end
      vcfc_pkg::ST_RD0: state_nxt = vcfc_pkg::ST_RD1;
      vcfc_pkg::ST_RD1: state_nxt = vcfc_pkg::ST_RD2;
      vcfc_pkg::ST_RD2: state_nxt = vcfc_pkg::ST_EMIT;
      vcfc_pkg::ST_EMIT: begin
        if (out_free) begin
          if (flush_r) begin
            state_nxt = (r_r == IDX_LAST) ? vcfc_pkg::ST_IDLE : vcfc_pkg::ST_RD0;
          end else begin
            state_nxt = last_r ? vcfc_pkg::ST_RD0 : vcfc_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = vcfc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, store ports, result load
  always_comb begin
    in_chan.ready = 1'b0;
    emit_load     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = vcfc_pkg::slot_addr(~p_r[0], r_r);
    ram_wdata     = row_r;
    ram_raddr_a   = vcfc_pkg::slot_addr(p_r[0], r_r);
    ram_raddr_b   = vcfc_pkg::slot_addr(p_r[0], r_up);
    unique case (state_r)
      vcfc_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        // first plane rows go straight into the store
        ram_we    = in_chan.valid && (i_r == IDX_ZERO);
        ram_waddr = vcfc_pkg::slot_addr(i_r[0], j_r);
        ram_wdata = in_chan.row_bits;
      end
      vcfc_pkg::ST_RD0: begin
        ram_raddr_a = vcfc_pkg::slot_addr(p_r[0], r_r);
        ram_raddr_b = vcfc_pkg::slot_addr(p_r[0], r_up);
      end
      vcfc_pkg::ST_RD1: begin
        ram_raddr_a = vcfc_pkg::slot_addr(p_r[0], r_dn);
        ram_raddr_b = vcfc_pkg::slot_addr(~p_r[0], r_r);
      end
      vcfc_pkg::ST_RD2: begin
        ram_raddr_a = vcfc_pkg::slot_addr(p_r[0], r_r);
      end
      vcfc_pkg::ST_EMIT: begin
        emit_load = out_free;
        // the new row replaces the previous plane's row only after it was read
        ram_we    = out_free && !flush_r;
      end
      default: begin
        in_chan.ready = 1'b0;
      end
    endcase
  end

  vcfc_ram #(
    .WIDTH (vcfc_pkg::ROW_W),
    .DEPTH (vcfc_pkg::DEPTH)
  ) u_plane_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  always_comb begin
    nbr.self = self_r;
    nbr.prv  = prv_r;
    nbr.nxt  = nxt_r;
    nbr.dn   = dn_r;
    nbr.up   = up_r;
  end

  vcfc_face_array u_faces (
    .rows  (nbr),
    .faces (faces)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vcfc_pkg::ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      flush_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      chunk_x_r   <= '0;
      chunk_y_r   <= '0;
      chunk_z_r   <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          vcfc_pkg::CFG_CHUNK_X: chunk_x_r <= cfg_wdata;
          vcfc_pkg::CFG_CHUNK_Y: chunk_y_r <= cfg_wdata;
          vcfc_pkg::CFG_CHUNK_Z: chunk_z_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_fire) begin
        last_r <= (i_r == IDX_LAST) && (j_r == IDX_LAST);
        if (j_r == IDX_LAST) begin
          j_r <= '0;
          i_r <= (i_r == IDX_LAST) ? IDX_ZERO : i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end

      if (state_r == vcfc_pkg::ST_EMIT && out_free) begin
        if (flush_r) begin
          if (r_r == IDX_LAST) begin
            flush_r <= 1'b0;
          end
        end else if (last_r) begin
          flush_r <= 1'b1;
          last_r  <= 1'b0;
        end
      end

      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= in_chan.row_bits;
      nxt_r <= in_chan.row_bits;
      p_r   <= i_r - 1'b1;
      r_r   <= j_r;
    end

    if (state_r == vcfc_pkg::ST_RD1) begin
      self_r <= ram_rdata_a;
      up_r   <= (r_r == IDX_LAST) ? '0 : ram_rdata_b;
    end
    if (state_r == vcfc_pkg::ST_RD2) begin
      dn_r  <= (r_r == IDX_ZERO) ? '0 : ram_rdata_a;
      prv_r <= (p_r == IDX_ZERO) ? '0 : ram_rdata_b;
    end

    if (state_r == vcfc_pkg::ST_EMIT && out_free) begin
      if (flush_r) begin
        r_r <= r_r + 1'b1;
      end else if (last_r) begin
        // final plane: same plane as the row just stored, no plane beyond it
        p_r   <= IDX_LAST;
        r_r   <= '0;
        nxt_r <= '0;
      end
    end

    if (emit_load) begin
      world_x_r <= (vcfc_pkg::WORLD_W'(chunk_x_r) << vcfc_pkg::ROW_SHIFT)
                   + vcfc_pkg::WORLD_W'(p_r);
      world_y_r <= (vcfc_pkg::WORLD_W'(chunk_y_r) << vcfc_pkg::ROW_SHIFT)
                   + vcfc_pkg::WORLD_W'(r_r);
      world_z_r <= vcfc_pkg::WORLD_W'(chunk_z_r) << vcfc_pkg::ROW_SHIFT;
      faces_r   <= faces;
      done_r    <= flush_r && (r_r == IDX_LAST);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.world_x      = world_x_r;
  assign out_chan.world_y      = world_y_r;
  assign out_chan.world_z_base = world_z_r;
  assign out_chan.left_faces   = faces_r.left;
  assign out_chan.right_faces  = faces_r.right;
  assign out_chan.bottom_faces = faces_r.bottom;
  assign out_chan.top_faces    = faces_r.top;
  assign out_chan.front_faces  = faces_r.front;
  assign out_chan.back_faces   = faces_r.back;
  assign out_chan.chunk_done   = done_r;

endmodule
